### hdl/htp_pkg.sv
// Package for the open-addressing hash table with triangular probing.
// Holds the transaction structs, status codes, hash constants and the
// command and status types shared by the controller and the datapath.
package htp_pkg;

	typedef struct packed {
		logic               command;
		logic [63:0]        key_primary;
		logic signed [31:0] key_secondary;
		logic [63:0]        insert_value;
	} htp_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] found_value;
		logic [10:0] entry_count;
	} htp_rsp_t;

	localparam logic CMD_INSERT = 1'b1;

	localparam logic [2:0] ST_HIT      = 3'd0;
	localparam logic [2:0] ST_MISS     = 3'd1;
	localparam logic [2:0] ST_INSERTED = 3'd2;
	localparam logic [2:0] ST_PRESENT  = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	localparam logic [10:0] COUNT_MAX   = 11'd2047;
	localparam logic [10:0] LIMIT_RESET = 11'd1024;

	localparam logic [63:0] C_GOLDEN = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] C_MIX1   = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] C_MIX2   = 64'h94d049bb133111eb;
	localparam int          SHIFT1   = 30;
	localparam int          SHIFT2   = 27;
	localparam int          SHIFT3   = 31;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_MUL0,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_MIX,
		S_PROBE_RD,
		S_PROBE_CHK,
		S_DELIVER
	} htp_state_t;

	typedef enum logic [1:0] {
		PP_LL,
		PP_LH,
		PP_HL
	} htp_pp_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD_HI
	} htp_acc_t;

	typedef enum logic [1:0] {
		RND_FIRST,
		RND_SECOND,
		RND_FINAL
	} htp_round_t;

	typedef struct packed {
		logic       clear_step;
		logic       load_req;
		htp_pp_t    mul_sel;
		htp_acc_t   acc_op;
		logic       mix_en;
		htp_round_t mix_round;
		logic       probe_rd;
		logic       probe_chk;
		logic       deliver;
	} htp_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic probe_done;
		logic out_free;
	} htp_sts_t;

endpackage

### hdl/hash_table_triangular_probe.sv
// Top level of the open-addressing hash table with triangular probing.
// Instantiates htp_ctrl and htp_datapath; depends on htp_pkg.
//
// After reset the block clears its value store, one slot per cycle; no
// request transaction is taken during that pass, although the probe limit
// may be written. Each request is then handled on its own: the home slot is
// hashed on a single shared 32x32 multiplier (three 64-bit products of three
// partial products each), and every slot examined takes a read state and a
// check state on the one memory port. The result waits in an output
// register, so the next request transaction is accepted while the previous
// response is still pending.
module hash_table_triangular_probe #(
	parameter int TABLE_SIZE_LOG2 = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  htp_pkg::htp_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output htp_pkg::htp_rsp_t rsp,
	input  logic              cfg_write,
	input  logic [10:0]       cfg_data
);
	import htp_pkg::*;

	htp_cmd_t cmd;
	htp_sts_t sts;

	htp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	htp_datapath #(
		.TABLE_SIZE_LOG2 (TABLE_SIZE_LOG2)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

### hdl/htp_ctrl.sv
// Controller state machine for the hash table: clearing pass, hash
// sequencing over the shared multiplier, probe walk and result hand-over.
// Depends on htp_pkg.
module htp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  htp_pkg::htp_sts_t sts,
	output htp_pkg::htp_cmd_t cmd
);
	import htp_pkg::*;

	htp_state_t state_q, state_d;
	htp_round_t rnd_q, rnd_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			rnd_q   <= RND_FIRST;
		end else begin
			state_q <= state_d;
			rnd_q   <= rnd_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		rnd_d         = rnd_q;
		cmd           = '0;
		cmd.mul_sel   = PP_LL;
		cmd.acc_op    = ACC_HOLD;
		cmd.mix_round = rnd_q;
		req_ready     = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_MUL0;
				end
			end
			S_MUL0: begin
				cmd.mul_sel = PP_LL;
				state_d     = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul_sel = PP_LH;
				cmd.acc_op  = ACC_LOAD;
				state_d     = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul_sel = PP_HL;
				cmd.acc_op  = ACC_ADD_HI;
				state_d     = S_MUL3;
			end
			S_MUL3: begin
				cmd.acc_op = ACC_ADD_HI;
				state_d    = S_MIX;
			end
			S_MIX: begin
				cmd.mix_en = 1'b1;
				unique case (rnd_q)
					RND_FIRST: begin
						rnd_d   = RND_SECOND;
						state_d = S_MUL0;
					end
					RND_SECOND: begin
						rnd_d   = RND_FINAL;
						state_d = S_MUL0;
					end
					default: begin
						rnd_d   = RND_FIRST;
						state_d = S_PROBE_RD;
					end
				endcase
			end
			S_PROBE_RD: begin
				cmd.probe_rd = 1'b1;
				state_d      = S_PROBE_CHK;
			end
			S_PROBE_CHK: begin
				cmd.probe_chk = 1'b1;
				state_d       = sts.probe_done ? S_DELIVER : S_PROBE_RD;
			end
			S_DELIVER: begin
				if (sts.out_free) begin
					cmd.deliver = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### hdl/htp_datapath.sv
// Datapath for the hash table: request registers, shared 32x32 multiplier
// with accumulator, splitmix rounds, slot memory, probe logic and output register.
// Depends on htp_pkg.
module htp_datapath #(
	parameter int TABLE_SIZE_LOG2 = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  htp_pkg::htp_cmd_t cmd,
	output htp_pkg::htp_sts_t sts,
	input  htp_pkg::htp_req_t req,
	input  logic              cfg_write,
	input  logic [10:0]       cfg_data,
	input  logic              rsp_ready,
	output logic              rsp_valid,
	output htp_pkg::htp_rsp_t rsp
);
	import htp_pkg::*;

	localparam int SLOTS = 1 << TABLE_SIZE_LOG2;

	typedef struct packed {
		logic [63:0] key_primary;
		logic [31:0] key_secondary;
		logic [63:0] value;
	} entry_t;

	entry_t mem [SLOTS];

	htp_req_t                   req_q;
	logic [63:0]                a_q, b_q, prod_q, acc_q;
	logic [TABLE_SIZE_LOG2-1:0] slot_q, stride_q;
	logic [10:0]                n_q, limit_q, count_q;
	entry_t                     rd_q;
	htp_rsp_t                   res_q, rsp_q;
	logic                       rsp_valid_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	logic [63:0] t0, m1, m2, m3;
	logic [10:0] eff_limit, count_nx, n_inc;
	logic        is_insert, empty, key_match, last, do_insert, probe_done;
	logic [2:0]  res_status;
	logic [63:0] res_found;
	logic        wr_en;
	entry_t      wr_data;

	always_comb begin
		unique case (cmd.mul_sel)
			PP_LH: begin
				mul_a = a_q[31:0];
				mul_b = b_q[63:32];
			end
			PP_HL: begin
				mul_a = a_q[63:32];
				mul_b = b_q[31:0];
			end
			default: begin
				mul_a = a_q[31:0];
				mul_b = b_q[31:0];
			end
		endcase
	end

	assign prod = {32'b0, mul_a} * {32'b0, mul_b};

	assign t0 = acc_q + C_GOLDEN;
	assign m1 = t0 ^ (t0 >> SHIFT1);
	assign m2 = acc_q ^ (acc_q >> SHIFT2);
	assign m3 = acc_q ^ (acc_q >> SHIFT3);

	assign eff_limit  = (limit_q == '0) ? 11'd1 : limit_q;
	assign n_inc      = n_q + 11'd1;
	assign is_insert  = req_q.command == CMD_INSERT;
	assign empty      = rd_q.value == '0;
	assign key_match  = (rd_q.key_primary == req_q.key_primary)
		&& (rd_q.key_secondary == $unsigned(req_q.key_secondary));
	assign last       = n_inc == eff_limit;
	assign do_insert  = empty && is_insert && (req_q.insert_value != '0);
	assign probe_done = empty || key_match || last;
	assign count_nx   = (do_insert && (count_q != COUNT_MAX)) ? count_q + 11'd1 : count_q;

	always_comb begin
		res_found = '0;
		priority if (empty) begin
			res_status = do_insert ? ST_INSERTED : ST_MISS;
		end else if (key_match) begin
			res_status = is_insert ? ST_PRESENT : ST_HIT;
			if (!is_insert) begin
				res_found = rd_q.value;
			end
		end else begin
			res_status = ST_FULL;
		end
	end

	assign wr_en   = cmd.clear_step || (cmd.probe_chk && do_insert);
	assign wr_data = cmd.clear_step ? entry_t'('0)
		: entry_t'{req_q.key_primary, $unsigned(req_q.key_secondary), req_q.insert_value};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[slot_q] <= wr_data;
		end
		if (cmd.probe_rd) begin
			rd_q <= mem[slot_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			limit_q     <= LIMIT_RESET;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_step) begin
				slot_q <= slot_q + 1'b1;
			end else if (cmd.mix_en && (cmd.mix_round == RND_FINAL)) begin
				slot_q <= m3[TABLE_SIZE_LOG2-1:0];
			end else if (cmd.probe_chk && !probe_done) begin
				slot_q <= slot_q + stride_q;
			end
			if (cfg_write) begin
				limit_q <= cfg_data;
			end
			if (cmd.probe_chk) begin
				count_q <= count_nx;
			end
			if (cmd.deliver) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req;
			a_q   <= req.key_primary;
			b_q   <= {{32{req.key_secondary[31]}}, $unsigned(req.key_secondary)};
		end else if (cmd.mix_en) begin
			unique case (cmd.mix_round)
				RND_FIRST: begin
					a_q <= m1;
					b_q <= C_MIX1;
				end
				RND_SECOND: begin
					a_q <= m2;
					b_q <= C_MIX2;
				end
				default: begin
				end
			endcase
		end
		prod_q <= prod;
		unique case (cmd.acc_op)
			ACC_LOAD:   acc_q <= prod_q;
			ACC_ADD_HI: acc_q <= acc_q + {prod_q[31:0], 32'b0};
			default:    acc_q <= acc_q;
		endcase
		if (cmd.mix_en && (cmd.mix_round == RND_FINAL)) begin
			stride_q <= TABLE_SIZE_LOG2'(1);
			n_q      <= '0;
		end else if (cmd.probe_chk && !probe_done) begin
			stride_q <= stride_q + 1'b1;
			n_q      <= n_inc;
		end
		if (cmd.probe_chk && probe_done) begin
			res_q <= '{status: res_status, found_value: res_found, entry_count: count_nx};
		end
		if (cmd.deliver) begin
			rsp_q <= res_q;
		end
	end

	assign sts.clear_last = &slot_q;
	assign sts.probe_done = probe_done;
	assign sts.out_free   = !rsp_valid_q || rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTH
	// The number of stored entries never falls.
	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= $past(count_q))
		else $error("entry count decreased");

	// A result is only moved to the output register once it is free.
	a_deliver_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.deliver |-> (!rsp_valid_q || rsp_ready))
		else $error("output register overwritten");

	// Only a lookup hit carries a stored value.
	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (rsp_q.status != ST_HIT)) |-> (rsp_q.found_value == '0))
		else $error("value returned without a hit");

	// The probe walk never examines more slots than the limit allows.
	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.probe_chk |-> (n_q < eff_limit))
		else $error("probe limit exceeded");
`endif

endmodule

### dv/htp_table_checker.sv
// Response checker for hash_table_triangular_probe.
// Watches the request, response and probe-limit ports, predicts every response
// from its own copy of the table and compares it; depends on htp_pkg.
module htp_table_checker #(
	parameter int TABLE_SIZE_LOG2 = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_ready,
	input  htp_pkg::htp_req_t req,
	input  logic              rsp_valid,
	input  logic              rsp_ready,
	input  htp_pkg::htp_rsp_t rsp,
	input  logic              cfg_write,
	input  logic [10:0]       cfg_data,
	output int                outstanding,
	output int                mismatches
);
	import htp_pkg::*;

	localparam int SLOTS = 1 << TABLE_SIZE_LOG2;

	logic [63:0] slot_primary [SLOTS];
	logic [31:0] slot_secondary [SLOTS];
	logic [63:0] slot_value [SLOTS];
	logic [10:0] entries;
	logic [10:0] probe_cap;
	htp_rsp_t    pending_responses [$];
	htp_rsp_t    want;
	int          mismatch_total = 0;

	assign mismatches = mismatch_total;

	task automatic flag_mismatch(input string field, input logic [63:0] exp_val,
			input logic [63:0] got_val);
		$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_val, got_val);
		mismatch_total++;
	endtask

	function automatic logic [63:0] home_hash(input logic [63:0] kp, input logic [31:0] ks);
		logic [63:0] z;
		z = kp * {{32{ks[31]}}, ks} + C_GOLDEN;
		z = (z ^ (z >> SHIFT1)) * C_MIX1;
		z = (z ^ (z >> SHIFT2)) * C_MIX2;
		return z ^ (z >> SHIFT3);
	endfunction

	// Walks the probe sequence exactly as the block should and applies any insert.
	function automatic htp_rsp_t resolve_request(input htp_req_t r);
		htp_rsp_t                   res;
		logic [63:0]                hash;
		logic [TABLE_SIZE_LOG2-1:0] slot;
		int                         tries;
		int                         stride;
		res.status = ST_FULL;
		res.found_value = '0;
		tries = (probe_cap == '0) ? 1 : int'(probe_cap);
		hash = home_hash(r.key_primary, r.key_secondary);
		slot = hash[TABLE_SIZE_LOG2-1:0];
		stride = 1;
		for (int n = 0; n < tries; n++) begin
			if (slot_value[slot] == '0) begin
				if (r.command == CMD_INSERT && r.insert_value != '0) begin
					slot_primary[slot] = r.key_primary;
					slot_secondary[slot] = r.key_secondary;
					slot_value[slot] = r.insert_value;
					if (entries != COUNT_MAX)
						entries = entries + 11'd1;
					res.status = ST_INSERTED;
				end else begin
					res.status = ST_MISS;
				end
				break;
			end
			if (slot_primary[slot] == r.key_primary && slot_secondary[slot] == r.key_secondary) begin
				if (r.command == CMD_INSERT) begin
					res.status = ST_PRESENT;
				end else begin
					res.status = ST_HIT;
					res.found_value = slot_value[slot];
				end
				break;
			end
			slot = slot + TABLE_SIZE_LOG2'(stride);
			stride++;
		end
		res.entry_count = entries;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_primary[i] = '0;
				slot_secondary[i] = '0;
				slot_value[i] = '0;
			end
			entries = '0;
			probe_cap = LIMIT_RESET;
			pending_responses.delete();
			outstanding <= 0;
		end else begin
			if (cfg_write)
				probe_cap = cfg_data;
			if (req_valid && req_ready)
				pending_responses.push_back(resolve_request(req));
			if (rsp_valid && rsp_ready) begin
				if (pending_responses.size() == 0) begin
					flag_mismatch("unrequested response status", '0, 64'(rsp.status));
				end else begin
					want = pending_responses.pop_front();
					if (rsp.status !== want.status)
						flag_mismatch("status", 64'(want.status), 64'(rsp.status));
					if (rsp.found_value !== want.found_value)
						flag_mismatch("found_value", want.found_value, rsp.found_value);
					if (rsp.entry_count !== want.entry_count)
						flag_mismatch("entry_count", 64'(want.entry_count),
							64'(rsp.entry_count));
				end
			end
			outstanding <= pending_responses.size();
		end
	end

endmodule

### dv/hash_table_triangular_probe_tb.sv
// Testbench top for hash_table_triangular_probe: drives lookups, inserts and
// probe-limit settings with random idling on both ports and gives the verdict.
// Depends on htp_pkg, the block itself and htp_table_checker.
module hash_table_triangular_probe_tb;
	import htp_pkg::*;

	localparam int     TABLE_LOG2  = 10;
	localparam int     SLOTS       = 1 << TABLE_LOG2;
	localparam logic   CMD_LOOKUP  = 1'b0;
	localparam int     HOLD_AT     = 500;
	localparam int     LONG_HOLD   = 300;
	localparam int     SETTLE      = 64;
	localparam int     ITEM_BUDGET = 2300;
	localparam longint CYCLE_LIMIT = 3 * (SLOTS + LONG_HOLD
		+ longint'(ITEM_BUDGET) * (17 + 2 * 2047 + 2 * 40));

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	htp_req_t    req = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	htp_rsp_t    rsp;
	logic        cfg_write = 1'b0;
	logic [10:0] cfg_data = '0;
	int          outstanding;
	int          mismatches;

	int          sent = 0;
	int          certain_fill = 0;
	bit          fill_is_certain = 1'b1;
	int          key_serial = 15;
	int          calm_items = 0;
	logic [63:0] pool_kp [$];
	logic [31:0] pool_ks [$];

	hash_table_triangular_probe #(.TABLE_SIZE_LOG2(TABLE_LOG2)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data)
	);

	htp_table_checker #(.TABLE_SIZE_LOG2(TABLE_LOG2)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.cfg_write   (cfg_write),
		.cfg_data    (cfg_data),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic htp_req_t request_of(input logic cmd, input logic [63:0] kp,
			input logic [31:0] ks, input logic [63:0] val);
		htp_req_t r;
		r.command = cmd;
		r.key_primary = kp;
		r.key_secondary = ks;
		r.insert_value = val;
		return r;
	endfunction

	// Every fresh key carries a serial number, so no two are equal. Colliding keys
	// have a zero product of their parts and therefore share one home slot.
	function automatic void new_key(output logic [63:0] kp, output logic [31:0] ks,
			input bit collide);
		key_serial++;
		kp = rand64();
		ks = $urandom;
		kp[11:0] = key_serial[11:0];
		if (collide) begin
			if ($urandom_range(0, 1) == 1) begin
				kp = '0;
				ks[11:0] = key_serial[11:0];
			end else begin
				ks = '0;
			end
		end
	endfunction

	function automatic int next_gap();
		int r;
		if (calm_items > 0) begin
			calm_items--;
			return 0;
		end
		if ($urandom_range(0, 29) == 0)
			calm_items = $urandom_range(20, 60);
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic offer(input htp_req_t item, input bit adds_entry);
		int gap;
		gap = next_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
		sent <= sent + 1;
		if (adds_entry) begin
			pool_kp.push_back(item.key_primary);
			pool_ks.push_back(item.key_secondary);
			if (fill_is_certain)
				certain_fill++;
		end
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic set_probe_limit(input logic [10:0] limit);
		wait_idle();
		cfg_write <= 1'b1;
		cfg_data <= limit;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic run_traffic(input int count);
		int          pick;
		int          idx;
		logic        cmd;
		logic [63:0] kp;
		logic [31:0] ks;
		logic [63:0] val;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			idx = $urandom_range(0, pool_kp.size() - 1);
			val = rand64();
			if (val == '0)
				val = 64'd1;
			if (pick < 30) begin
				new_key(kp, ks, $urandom_range(0, 3) == 0);
				offer(request_of(CMD_INSERT, kp, ks, val), 1'b1);
			end else if (pick < 55) begin
				offer(request_of(CMD_LOOKUP, pool_kp[idx], pool_ks[idx], rand64()), 1'b0);
			end else if (pick < 65) begin
				offer(request_of(CMD_INSERT, pool_kp[idx], pool_ks[idx], val), 1'b0);
			end else if (pick < 75) begin
				new_key(kp, ks, $urandom_range(0, 2) == 0);
				offer(request_of(CMD_LOOKUP, kp, ks, rand64()), 1'b0);
			end else if (pick < 80) begin
				if (pick[0])
					new_key(kp, ks, 1'b0);
				else
					{kp, ks} = {pool_kp[idx], pool_ks[idx]};
				offer(request_of(CMD_INSERT, kp, ks, '0), 1'b0);
			end else if (pick < 90) begin
				cmd = 1'($urandom_range(0, 1));
				val = ($urandom_range(0, 7) == 0) ? '0 : rand64();
				offer(request_of(cmd, rand64(), $urandom, val),
					cmd == CMD_INSERT && val != '0);
			end else begin
				// Keys that match a stored key in one part only.
				kp = pool_kp[idx];
				ks = pool_ks[idx];
				if (pick[0])
					ks[$urandom_range(0, 31)] ^= 1'b1;
				else
					kp[$urandom_range(0, 63)] ^= 1'b1;
				cmd = pick[1] ? CMD_INSERT : CMD_LOOKUP;
				offer(request_of(cmd, kp, ks, val), cmd == CMD_INSERT);
			end
		end
	endtask

	initial begin
		int stall_left;
		int calm_cycles;
		int r;
		bit held;
		stall_left = 0;
		calm_cycles = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && sent >= HOLD_AT) begin
				held = 1'b1;
				rsp_ready <= 1'b0;
				for (int c = 0; c < LONG_HOLD; c++)
					@(posedge clk);
			end
			if (stall_left > 0) begin
				rsp_ready <= 1'b0;
				stall_left--;
			end else if (calm_cycles > 0) begin
				rsp_ready <= 1'b1;
				calm_cycles--;
			end else begin
				r = $urandom_range(0, 199);
				if (r < 160) begin
					rsp_ready <= 1'b1;
				end else if (r < 194) begin
					rsp_ready <= 1'b0;
					stall_left = $urandom_range(0, 2);
				end else if (r < 198) begin
					rsp_ready <= 1'b0;
					stall_left = $urandom_range(9, 39);
				end else begin
					rsp_ready <= 1'b1;
					calm_cycles = $urandom_range(50, 200);
				end
			end
		end
	end

	initial begin
		longint cycles;
		for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
			@(posedge clk);
		$display("hash_table_triangular_probe test failed");
		$finish;
	end

	initial begin
		int          need;
		int          idx;
		logic [63:0] kp;
		logic [31:0] ks;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Chains on the shared home slot of zero products, extreme keys and values,
		// duplicate inserts and inserts of the reserved empty value.
		offer(request_of(CMD_LOOKUP, '0, '0, '1), 1'b0);
		offer(request_of(CMD_INSERT, '0, '0, '1), 1'b1);
		offer(request_of(CMD_LOOKUP, '0, '0, '0), 1'b0);
		offer(request_of(CMD_INSERT, '0, 32'h8000_0000, 64'd1), 1'b1);
		offer(request_of(CMD_INSERT, '0, 32'h7fff_ffff, rand64() | 64'd1), 1'b1);
		offer(request_of(CMD_INSERT, '1, '0, rand64() | 64'd1), 1'b1);
		offer(request_of(CMD_LOOKUP, '1, '0, '0), 1'b0);
		offer(request_of(CMD_INSERT, '0, '0, 64'd5), 1'b0);
		offer(request_of(CMD_LOOKUP, '0, '0, '0), 1'b0);
		offer(request_of(CMD_INSERT, 64'd1, 32'd1, '0), 1'b0);
		offer(request_of(CMD_LOOKUP, 64'd1, 32'd1, '0), 1'b0);
		offer(request_of(CMD_INSERT, '0, 32'h8000_0000, '0), 1'b0);
		offer(request_of(CMD_INSERT, '1, 32'h7fff_ffff, 64'h8000_0000_0000_0000), 1'b1);
		offer(request_of(CMD_INSERT, '1, 32'h8000_0000, 64'h7fff_ffff_ffff_ffff), 1'b1);
		offer(request_of(CMD_LOOKUP, '1, 32'h8000_0000, '0), 1'b0);
		offer(request_of(CMD_LOOKUP, '1, '1, '0), 1'b0);
		offer(request_of(CMD_LOOKUP, 64'h8000_0000_0000_0000, 32'd2, '0), 1'b0);
		offer(request_of(CMD_INSERT, 64'h8000_0000_0000_0000, 32'd2, rand64() | 64'd1), 1'b1);
		offer(request_of(CMD_LOOKUP, '0, 32'h8000_0000, '0), 1'b0);
		offer(request_of(CMD_INSERT, 64'd1, 32'd1, 64'd1), 1'b1);
		offer(request_of(CMD_LOOKUP, 64'd1, 32'd1, '0), 1'b0);

		fill_is_certain = 1'b0;
		set_probe_limit(11'd0);
		run_traffic(40);
		set_probe_limit(11'd1);
		run_traffic(40);
		set_probe_limit(11'($urandom_range(2, 8)));
		run_traffic(40);
		set_probe_limit(11'($urandom_range(9, 1023)));
		run_traffic(40);
		fill_is_certain = 1'b1;
		set_probe_limit(11'd2047);
		run_traffic(40);
		set_probe_limit(LIMIT_RESET);
		run_traffic(600);
		wait_idle();
		run_traffic(400);

		// Fill the table; a few inserts beyond the known count find it full.
		need = SLOTS - certain_fill + 4;
		for (int i = 0; i < need; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				idx = $urandom_range(0, pool_kp.size() - 1);
				offer(request_of(CMD_LOOKUP, pool_kp[idx], pool_ks[idx], rand64()), 1'b0);
			end
			new_key(kp, ks, $urandom_range(0, 9) == 0);
			offer(request_of(CMD_INSERT, kp, ks, rand64() | 64'd1), 1'b1);
		end

		fill_is_certain = 1'b0;
		new_key(kp, ks, 1'b0);
		offer(request_of(CMD_LOOKUP, kp, ks, '0), 1'b0);
		offer(request_of(CMD_INSERT, kp, ks, rand64() | 64'd1), 1'b0);
		offer(request_of(CMD_LOOKUP, '0, '0, '0), 1'b0);
		offer(request_of(CMD_INSERT, '0, '0, 64'd9), 1'b0);
		set_probe_limit(11'd2047);
		new_key(kp, ks, 1'b1);
		offer(request_of(CMD_LOOKUP, kp, ks, '0), 1'b0);
		offer(request_of(CMD_INSERT, kp, ks, rand64() | 64'd1), 1'b0);
		offer(request_of(CMD_LOOKUP, pool_kp[pool_kp.size() - 1], pool_ks[pool_ks.size() - 1],
			'0), 1'b0);
		set_probe_limit(11'd3);
		run_traffic(20);
		set_probe_limit(11'd0);
		run_traffic(15);

		wait_idle();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("hash_table_triangular_probe test passed");
		else
			$display("hash_table_triangular_probe test failed");
		$finish;
	end

endmodule

### filelist.f
hdl/htp_pkg.sv
hdl/htp_ctrl.sv
hdl/htp_datapath.sv
hdl/hash_table_triangular_probe.sv
dv/htp_table_checker.sv
dv/hash_table_triangular_probe_tb.sv
